// ===== src/stsc_pkg.sv =====
// shared types, token codes and character class helpers for the token scanner
package stsc_pkg;

    localparam int POSITION_BITS_DEF   = 16;
    localparam int KEYWORD_MAX_LEN_DEF = 6;
    localparam int KW_COUNT            = 14;
    localparam int RUN_MAX             = 3;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_ERR     = 6'd1;
    localparam logic [5:0] K_NUM     = 6'd2;
    localparam logic [5:0] K_STR     = 6'd3;
    localparam logic [5:0] K_ID      = 6'd4;
    localparam logic [5:0] K_PLUS    = 6'd5;
    localparam logic [5:0] K_MINUS   = 6'd7;
    localparam logic [5:0] K_STAR    = 6'd9;
    localparam logic [5:0] K_SLASH   = 6'd11;
    localparam logic [5:0] K_DSLASH  = 6'd13;
    localparam logic [5:0] K_DSLASHE = 6'd14;
    localparam logic [5:0] K_PCT     = 6'd15;
    localparam logic [5:0] K_LT      = 6'd17;
    localparam logic [5:0] K_GT      = 6'd19;
    localparam logic [5:0] K_ASSIGN  = 6'd21;
    localparam logic [5:0] K_BANG    = 6'd23;
    localparam logic [5:0] K_LPAREN  = 6'd25;
    localparam logic [5:0] K_RPAREN  = 6'd26;
    localparam logic [5:0] K_LBRACE  = 6'd27;
    localparam logic [5:0] K_RBRACE  = 6'd28;
    localparam logic [5:0] K_LBRACK  = 6'd29;
    localparam logic [5:0] K_RBRACK  = 6'd30;
    localparam logic [5:0] K_SEMI    = 6'd31;
    localparam logic [5:0] K_COMMA   = 6'd32;
    localparam logic [5:0] K_DOT     = 6'd33;
    localparam logic [5:0] K_COLON   = 6'd34;
    localparam logic [5:0] K_KW0     = 6'd35;
    localparam logic [5:0] K_NONE    = 6'd0;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_UNTERM     = 2'd2;

    // keyword spellings, first character in the low byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0000_7361,   // as
        64'h0000_0000_0064_6E61,   // and
        64'h0000_0073_7361_6C63,   // class
        64'h0000_0000_6573_6C65,   // else
        64'h0000_0065_736C_6166,   // false
        64'h0000_0000_0000_6E66,   // fn
        64'h0000_0000_0000_6669,   // if
        64'h0000_7472_6F70_6D69,   // import
        64'h0000_0000_6C6C_756E,   // null
        64'h0000_0000_0000_726F,   // or
        64'h0000_0074_6E69_7270,   // print
        64'h0000_6E72_7574_6572,   // return
        64'h0000_0000_6575_7274,   // true
        64'h0000_0000_0072_6176    // var
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd3, 4'd5, 4'd4, 4'd5, 4'd2, 4'd2,
        4'd6, 4'd4, 4'd2, 4'd5, 4'd6, 4'd4, 4'd3
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic [1:0]  err;
        logic        last;
    } token_t;

    function automatic logic [5:0] op_code(input logic [7:0] c);
        logic [5:0] k;
        k = K_NONE;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h25:   k = K_PCT;
            8'h3C:   k = K_LT;
            8'h3E:   k = K_GT;
            8'h3D:   k = K_ASSIGN;
            8'h21:   k = K_BANG;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] single_code(input logic [7:0] c);
        logic [5:0] k;
        k = K_NONE;
        case (c)
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            8'h2E:   k = K_DOT;
            8'h3A:   k = K_COLON;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    function automatic logic [15:0] sat16(input logic [32:0] v);
        return (v > 33'h0_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

// ===== src/stsc_core.sv =====
// scan state and per-byte token decision logic
module stsc_core
    import stsc_pkg::*;
#(
    parameter int POSITION_BITS   = POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [7:0]       step_byte,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_data,
    output token_t [2:0]     tokens,
    output logic [1:0]       token_count
);

    localparam int PW = POSITION_BITS;
    localparam int WW = 8 * KEYWORD_MAX_LEN;
    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_OP, M_DSLASH, M_INT, M_DOT, M_FRAC, M_STRING, M_WORD
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [15:0]    line_reg, line_next;
    logic [PW-1:0]  begin_reg, begin_next;
    logic [WW-1:0]  prefix_reg, prefix_next;
    logic [LW-1:0]  wlen_reg, wlen_next;
    logic [7:0]     pend_reg, pend_next;
    logic [15:0]    first_line_reg;

    token_t         tok_a, tok_b, tok_c;
    logic           a_v, b_v, c_v;
    logic           fresh;
    logic [PW-1:0]  span_p, dot_pos, span_d;
    logic [5:0]     word_kind, sc, oc;

    // keyword lookup over the kept prefix
    always_comb
    begin
        word_kind = K_ID;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (wlen_reg == LW'(KW_LEN[k]) && prefix_reg == WW'(KW_TEXT[k]))
                word_kind = K_KW0 + 6'(k);
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        begin_next  = begin_reg;
        prefix_next = prefix_reg;
        wlen_next   = wlen_reg;
        pend_next   = pend_reg;
        a_v   = 1'b0;
        b_v   = 1'b0;
        c_v   = 1'b0;
        fresh = 1'b0;
        tok_a = '{kind: K_NONE, start: '0, length: '0, line: line_reg, err: ERR_NONE,
                  last: 1'b0};
        tok_b = tok_a;
        tok_c = tok_a;
        span_p  = (pos_reg > begin_reg) ? pos_reg - begin_reg : '0;
        dot_pos = (pos_reg > begin_reg) ? pos_reg - PW'(1) : pos_reg;
        span_d  = (dot_pos > begin_reg) ? dot_pos - begin_reg : '0;
        oc = op_code(step_byte);
        sc = single_code(step_byte);

        unique case (mode_reg)
            M_COMMENT:
            begin
                if (step_byte == 8'h00)
                begin
                    mode_next = M_IDLE;
                    fresh     = 1'b1;
                end
                else if (step_byte == 8'h0A)
                begin
                    if (line_reg != 16'hFFFF)
                        line_next = line_reg + 16'd1;
                    mode_next = M_IDLE;
                end
            end
            M_OP:
            begin
                mode_next = M_IDLE;
                pend_next = 8'h00;
                a_v = 1'b1;
                tok_a.start = sat16(33'(begin_reg));
                if (step_byte == 8'h3D)
                begin
                    tok_a.kind   = op_code(pend_reg) + 6'd1;
                    tok_a.length = sat16(33'(span_p) + 33'd1);
                end
                else if (pend_reg == 8'h2F && step_byte == 8'h2F)
                begin
                    a_v       = 1'b0;
                    mode_next = M_DSLASH;
                    pend_next = pend_reg;
                end
                else
                begin
                    tok_a.kind   = op_code(pend_reg);
                    tok_a.length = sat16(33'(span_p));
                    fresh = 1'b1;
                end
            end
            M_DSLASH:
            begin
                mode_next = M_IDLE;
                pend_next = 8'h00;
                a_v = 1'b1;
                tok_a.start = sat16(33'(begin_reg));
                if (step_byte == 8'h3D)
                begin
                    tok_a.kind   = K_DSLASHE;
                    tok_a.length = sat16(33'(span_p) + 33'd1);
                end
                else
                begin
                    tok_a.kind   = K_DSLASH;
                    tok_a.length = sat16(33'(span_p));
                    fresh = 1'b1;
                end
            end
            M_INT, M_FRAC:
            begin
                if (mode_reg == M_INT && step_byte == 8'h2E)
                    mode_next = M_DOT;
                else if (!digit_char(step_byte))
                begin
                    a_v = 1'b1;
                    tok_a.kind   = K_NUM;
                    tok_a.start  = sat16(33'(begin_reg));
                    tok_a.length = sat16(33'(span_p));
                    mode_next = M_IDLE;
                    fresh = 1'b1;
                end
            end
            M_DOT:
            begin
                if (digit_char(step_byte))
                    mode_next = M_FRAC;
                else
                begin
                    // number without fraction, then the dot on its own
                    a_v = 1'b1;
                    tok_a.kind   = K_NUM;
                    tok_a.start  = sat16(33'(begin_reg));
                    tok_a.length = sat16(33'(span_d));
                    b_v = 1'b1;
                    tok_b.kind   = K_DOT;
                    tok_b.start  = sat16(33'(dot_pos));
                    tok_b.length = 16'd1;
                    mode_next = M_IDLE;
                    fresh = 1'b1;
                end
            end
            M_STRING:
            begin
                if (step_byte == 8'h22)
                begin
                    a_v = 1'b1;
                    tok_a.kind   = K_STR;
                    tok_a.start  = sat16(33'(begin_reg) + 33'd1);
                    tok_a.length = sat16((span_p != '0) ? 33'(span_p) - 33'd1 : 33'd0);
                    mode_next = M_IDLE;
                end
                else if (step_byte == 8'h00)
                begin
                    a_v = 1'b1;
                    tok_a.kind   = K_ERR;
                    tok_a.start  = sat16(33'(begin_reg));
                    tok_a.length = sat16(33'(span_p));
                    tok_a.err    = ERR_UNTERM;
                    mode_next = M_IDLE;
                    fresh = 1'b1;
                end
            end
            M_WORD:
            begin
                if (digit_char(step_byte) || letter_char(step_byte))
                begin
                    if (wlen_reg < LW'(KEYWORD_MAX_LEN))
                    begin
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                        begin
                            if (wlen_reg == LW'(i))
                                prefix_next[8*i +: 8] = step_byte;
                        end
                        wlen_next = wlen_reg + LW'(1);
                    end
                    else
                        wlen_next = LW'(KEYWORD_MAX_LEN + 1);
                end
                else
                begin
                    a_v = 1'b1;
                    tok_a.kind   = word_kind;
                    tok_a.start  = sat16(33'(begin_reg));
                    tok_a.length = sat16(33'(span_p));
                    prefix_next = '0;
                    wlen_next   = '0;
                    mode_next   = M_IDLE;
                    fresh = 1'b1;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
                fresh = 1'b1;
            end
        endcase

        // byte handled as from idle: eof, blank, newline, comment or the start of a new token
        if (fresh)
        begin
            tok_c.start  = sat16(33'(pos_reg));
            tok_c.length = 16'd1;
            if (step_byte == 8'h00)
            begin
                c_v = 1'b1;
                tok_c.kind   = K_EOF;
                tok_c.length = 16'd0;
                mode_next   = M_IDLE;
                pos_next    = '0;
                line_next   = first_line_reg;
                begin_next  = '0;
                prefix_next = '0;
                wlen_next   = '0;
                pend_next   = 8'h00;
            end
            else if (step_byte == 8'h20 || step_byte == 8'h09)
            begin
                mode_next = M_IDLE;
            end
            else if (step_byte == 8'h0A)
            begin
                if (line_reg != 16'hFFFF)
                    line_next = line_reg + 16'd1;
            end
            else if (step_byte == 8'h23)
                mode_next = M_COMMENT;
            else
            begin
                begin_next = pos_reg;
                if (oc != K_NONE)
                begin
                    mode_next = M_OP;
                    pend_next = step_byte;
                end
                else if (sc != K_NONE)
                begin
                    c_v = 1'b1;
                    tok_c.kind = sc;
                end
                else if (step_byte == 8'h22)
                    mode_next = M_STRING;
                else if (digit_char(step_byte))
                    mode_next = M_INT;
                else if (letter_char(step_byte))
                begin
                    mode_next   = M_WORD;
                    prefix_next = WW'(step_byte);
                    wlen_next   = LW'(1);
                end
                else
                begin
                    c_v = 1'b1;
                    tok_c.kind = K_ERR;
                    tok_c.err  = ERR_UNEXPECTED;
                end
            end
        end

        if (step_byte != 8'h00 && pos_reg != {PW{1'b1}})
            pos_next = pos_reg + PW'(1);
    end

    // pack the candidates in order and mark the last one
    always_comb
    begin
        logic [1:0] n;
        n = 2'd0;
        tokens = '0;
        if (a_v)
        begin
            tokens[n] = tok_a;
            n = n + 2'd1;
        end
        if (b_v)
        begin
            tokens[n] = tok_b;
            n = n + 2'd1;
        end
        if (c_v)
        begin
            tokens[n] = tok_c;
            n = n + 2'd1;
        end
        if (n != 2'd0)
            tokens[n - 2'd1].last = 1'b1;
        token_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            pos_reg        <= '0;
            line_reg       <= 16'd1;
            begin_reg      <= '0;
            prefix_reg     <= '0;
            wlen_reg       <= '0;
            pend_reg       <= 8'h00;
            first_line_reg <= 16'd1;
        end
        else
        begin
            if (step_en)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                begin_reg  <= begin_next;
                prefix_reg <= prefix_next;
                wlen_reg   <= wlen_next;
                pend_reg   <= pend_next;
            end
            // a write at text start also reloads the line counter
            if (cfg_we && pos_reg == '0)
                line_reg <= cfg_data;
            else if (step_en)
                line_reg <= line_next;
            if (cfg_we)
                first_line_reg <= cfg_data;
        end
    end

endmodule

// ===== src/script_token_scanner.sv =====
// top level of the streaming token scanner: input register, core and result queue
//
// in channel: one source byte per request on text_byte (in_valid/in_ready);
//   a zero byte ends the text, flushes the pending token and sends eof
// out channel: one token per request (out_valid/out_ready) with kind, start,
//   length, line, error kind and last_of_run marking the last token of a byte
// cfg channel: cfg_valid/cfg_ready write first_line; ready is always high,
//   write only while the scanner is idle
// path: a taken byte is held in the input register, scanned from there, and its
//   tokens join the result queue, whose head drives the out ports
// throughput: one byte per cycle while the receiver is ready and bytes make
//   at most one token each; a byte is scanned only when three of the four
//   queue slots are sure to be free, so runs of bytes that make two or three
//   tokens are paced by the queue drain
// receiver stall: tokens stay in the queue, the input register holds one
//   byte and in_ready drops once that byte cannot be scanned
// reset: scanner idle, position zero, line counter and first_line set to one,
//   queue empty
module script_token_scanner
    import stsc_pkg::*;
#(
    parameter int POSITION_BITS   = POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] first_line,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic [15:0] token_line,
    output logic [1:0]  error_kind,
    output logic        last_of_run
);

    localparam int QD = 4;

    logic          byte_valid_reg;
    logic [7:0]    byte_reg;
    token_t        q_reg [QD];
    token_t        q_next [QD];
    token_t        shifted [QD];
    logic [2:0]    q_cnt_reg, q_cnt_next;
    logic [2:0]    remain;
    logic          pop, scan;
    token_t [2:0]  new_tok;
    logic [1:0]    new_cnt;

    assign cfg_ready = 1'b1;
    assign pop       = out_valid && out_ready;
    assign remain    = q_cnt_reg - 3'(pop);
    // scan only when three slots are sure to be free
    assign scan      = byte_valid_reg && (remain <= 3'd1);
    assign in_ready  = !byte_valid_reg || scan;

    stsc_core #(
        .POSITION_BITS   (POSITION_BITS),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (scan),
        .step_byte   (byte_reg),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (first_line),
        .tokens      (new_tok),
        .token_count (new_cnt)
    );

    // queue: drop the head on pop, then append the new tokens
    always_comb
    begin
        logic [2:0] j;
        for (int i = 0; i < QD; i++)
        begin
            if (pop && i < QD - 1)
                shifted[i] = q_reg[i + 1];
            else
                shifted[i] = q_reg[i];
        end
        for (int i = 0; i < QD; i++)
        begin
            j = 3'(i) - remain;
            if (3'(i) < remain)
                q_next[i] = shifted[i];
            else if (scan && j < 3'(new_cnt))
                q_next[i] = new_tok[j[1:0]];
            else
                q_next[i] = shifted[i];
        end
        q_cnt_next = remain + (scan ? 3'(new_cnt) : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            q_cnt_reg      <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                byte_valid_reg <= 1'b1;
            else if (scan)
                byte_valid_reg <= 1'b0;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= text_byte;
        for (int i = 0; i < QD; i++)
            q_reg[i] <= q_next[i];
    end

    assign out_valid    = (q_cnt_reg != 3'd0);
    assign token_kind   = q_reg[0].kind;
    assign token_start  = q_reg[0].start;
    assign token_length = q_reg[0].length;
    assign token_line   = q_reg[0].line;
    assign error_kind   = q_reg[0].err;
    assign last_of_run  = q_reg[0].last;

endmodule

// ===== src/stsc_checker.sv =====
// port-level checks for the token scanner and their binding
module stsc_checker
    import stsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_kind,
    input logic [15:0] token_start,
    input logic [15:0] token_length,
    input logic [1:0]  error_kind,
    input logic        last_of_run
);

    // a stalled token stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
            && $stable(token_start) && $stable(token_length))
        else $error("token changed while stalled");

    // eof is empty and closes its run
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_EOF |-> last_of_run && token_length == 16'd0)
        else $error("eof not last or not empty");

    // error kind only on error tokens
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != K_ERR |-> error_kind == ERR_NONE)
        else $error("error kind on non-error token");

    // error tokens always carry a cause
    a_err_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_ERR |->
            error_kind == ERR_UNEXPECTED || error_kind == ERR_UNTERM)
        else $error("error token without cause");

endmodule

bind script_token_scanner stsc_checker u_stsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .error_kind   (error_kind),
    .last_of_run  (last_of_run)
);
